>>> rtl/core/irc_tok_pkg.sv
// Shared types and constants of the message line tokenizer.
`default_nettype none

package irc_tok_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [3:0] MAX_MIDDLE_PARAMS = 4'd14;

    localparam logic [2:0] KIND_DROP     = 3'd0;
    localparam logic [2:0] KIND_PREFIX   = 3'd1;
    localparam logic [2:0] KIND_COMMAND  = 3'd2;
    localparam logic [2:0] KIND_MIDDLE   = 3'd3;
    localparam logic [2:0] KIND_TRAILING = 3'd4;

    typedef enum logic [2:0] {
        CC_OTHER,
        CC_SPACE,
        CC_COLON,
        CC_NUL,
        CC_FINAL_CR
    } t_char_class;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       line_end;
    } t_tok_in;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] field_kind;
        logic [3:0] param_index;
        logic       token_start;
        logic       end_of_line;
        logic       line_valid;
        logic       trailing_present;
        logic [3:0] param_total;
        logic       command_present;
    } t_tok_out;

    typedef struct packed {
        logic [7:0]  byte_val;
        logic        line_end;
        t_char_class char_class;
    } t_tok_item;

    typedef struct packed {
        logic      valid;
        t_tok_item item;
    } t_tok_push;

    typedef struct packed {
        logic      valid;
        t_tok_item item;
    } t_tok_head;

endpackage

`default_nettype wire

>>> rtl/core/irc_tok_chan.sv
// Valid/ready channel interfaces for the tokenizer input and result streams.
`default_nettype none

interface irc_tok_in_chan ();
    logic                 valid;
    logic                 ready;
    irc_tok_pkg::t_tok_in payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface irc_tok_out_chan ();
    logic                  valid;
    logic                  ready;
    irc_tok_pkg::t_tok_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/irc_tok_front.sv
// Front end: accepts input bytes, classifies them and pushes them into the queue.
`default_nettype none

module irc_tok_front (
    irc_tok_in_chan.sink            i_in,
    input  wire logic               i_full,
    output irc_tok_pkg::t_tok_push  o_push
);
    import irc_tok_pkg::*;

    t_char_class cls;

    always_comb begin
        if (i_in.payload.byte_in == CHAR_NUL) begin
            cls = CC_NUL;
        end else if (i_in.payload.line_end && i_in.payload.byte_in == CHAR_CR) begin
            cls = CC_FINAL_CR;
        end else if (i_in.payload.byte_in == CHAR_SPACE) begin
            cls = CC_SPACE;
        end else if (i_in.payload.byte_in == CHAR_COLON) begin
            cls = CC_COLON;
        end else begin
            cls = CC_OTHER;
        end
    end

    assign i_in.ready = !i_full;

    always_comb begin
        o_push.valid           = i_in.valid && !i_full;
        o_push.item.byte_val   = i_in.payload.byte_in;
        o_push.item.line_end   = i_in.payload.line_end;
        o_push.item.char_class = cls;
    end

endmodule

`default_nettype wire

>>> rtl/core/irc_tok_queue.sv
// Short first-word fall-through queue between the front end and the back end.
`default_nettype none

module irc_tok_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  irc_tok_pkg::t_tok_push  i_push,
    output logic                    o_full,
    output irc_tok_pkg::t_tok_head  o_head,
    input  wire logic               i_pop
);
    import irc_tok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_tok_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign push = i_push.valid;
    assign pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full = (r_count == FULL_CNT);

    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.item  = r_mem[r_rd_ptr];
    end

endmodule

`default_nettype wire

>>> rtl/core/irc_tok_back.sv
// Back end: message phase state machine and the registered result stage.
`default_nettype none

module irc_tok_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  irc_tok_pkg::t_tok_head  i_head,
    output logic                    o_pop,
    irc_tok_out_chan.source         o_out
);
    import irc_tok_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_PREFIX,
        PH_AFTER_PREFIX,
        PH_COMMAND,
        PH_GAP,
        PH_MIDDLE,
        PH_TRAILING
    } t_phase;

    t_phase     r_phase;
    logic [3:0] r_param_count;
    logic       r_nul_seen;
    logic       r_trailing_open;
    logic       r_command_seen;
    logic       r_first_pending;
    logic       r_out_valid;
    t_tok_out   r_out;

    t_phase     n_phase;
    logic [3:0] n_param_count;
    logic       n_nul_seen;
    logic       n_trailing_open;
    logic       n_command_seen;
    logic       n_first_pending;
    t_tok_out   n_out;

    logic       sp;
    logic       colon;
    logic       line_ok;
    logic       last;

    assign o_pop = i_head.valid && (!r_out_valid || o_out.ready);
    assign last  = i_head.item.line_end;
    assign sp    = (i_head.item.char_class == CC_SPACE);
    assign colon = (i_head.item.char_class == CC_COLON);

    always_comb begin
        n_phase         = r_phase;
        n_param_count   = r_param_count;
        n_nul_seen      = r_nul_seen;
        n_trailing_open = r_trailing_open;
        n_command_seen  = r_command_seen;
        n_first_pending = r_first_pending;
        n_out.field_kind  = KIND_DROP;
        n_out.param_index = '0;
        n_out.token_start = 1'b0;

        case (i_head.item.char_class)
            CC_NUL: begin
                n_nul_seen = 1'b1;
            end
            CC_FINAL_CR: begin
            end
            default: begin
                case (r_phase)
                    PH_LEAD: begin
                        if (colon) begin
                            n_phase         = PH_PREFIX;
                            n_first_pending = 1'b1;
                        end else if (!sp) begin
                            n_out.field_kind  = KIND_COMMAND;
                            n_out.token_start = 1'b1;
                            n_command_seen    = 1'b1;
                            n_phase           = PH_COMMAND;
                        end
                    end
                    PH_PREFIX: begin
                        n_first_pending = 1'b0;
                        if (sp) begin
                            n_phase = PH_AFTER_PREFIX;
                        end else begin
                            n_out.field_kind  = KIND_PREFIX;
                            n_out.token_start = r_first_pending;
                        end
                    end
                    PH_AFTER_PREFIX: begin
                        if (!sp) begin
                            n_out.field_kind  = KIND_COMMAND;
                            n_out.token_start = 1'b1;
                            n_command_seen    = 1'b1;
                            n_phase           = PH_COMMAND;
                        end
                    end
                    PH_COMMAND: begin
                        if (sp) begin
                            n_phase = PH_GAP;
                        end else begin
                            n_out.field_kind = KIND_COMMAND;
                        end
                    end
                    PH_GAP: begin
                        if (!sp) begin
                            if (r_param_count >= MAX_MIDDLE_PARAMS) begin
                                n_trailing_open = 1'b1;
                                n_phase         = PH_TRAILING;
                                if (colon) begin
                                    n_first_pending = 1'b1;
                                end else begin
                                    n_out.field_kind  = KIND_TRAILING;
                                    n_out.token_start = 1'b1;
                                    n_first_pending   = 1'b0;
                                end
                            end else if (colon) begin
                                n_trailing_open = 1'b1;
                                n_phase         = PH_TRAILING;
                                n_first_pending = 1'b1;
                            end else begin
                                n_out.field_kind  = KIND_MIDDLE;
                                n_out.param_index = r_param_count;
                                n_out.token_start = 1'b1;
                                n_param_count     = r_param_count + 1'b1;
                                n_phase           = PH_MIDDLE;
                            end
                        end
                    end
                    PH_MIDDLE: begin
                        if (sp) begin
                            n_phase = PH_GAP;
                        end else begin
                            n_out.field_kind  = KIND_MIDDLE;
                            n_out.param_index = r_param_count - 1'b1;
                        end
                    end
                    PH_TRAILING: begin
                        n_out.field_kind  = KIND_TRAILING;
                        n_out.token_start = r_first_pending;
                        n_first_pending   = 1'b0;
                    end
                    default: begin
                        n_phase = PH_LEAD;
                    end
                endcase
            end
        endcase

        line_ok                = !n_nul_seen;
        n_out.byte_out         = i_head.item.byte_val;
        n_out.end_of_line      = last;
        n_out.line_valid       = line_ok;
        n_out.trailing_present = n_trailing_open;
        n_out.param_total      = n_param_count;
        n_out.command_present  = n_command_seen;
        if (last && !line_ok) begin
            n_out.trailing_present = 1'b0;
            n_out.param_total      = '0;
            n_out.command_present  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_LEAD;
            r_param_count   <= '0;
            r_nul_seen      <= 1'b0;
            r_trailing_open <= 1'b0;
            r_command_seen  <= 1'b0;
            r_first_pending <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
                if (last) begin
                    r_phase         <= PH_LEAD;
                    r_param_count   <= '0;
                    r_nul_seen      <= 1'b0;
                    r_trailing_open <= 1'b0;
                    r_command_seen  <= 1'b0;
                    r_first_pending <= 1'b0;
                end else begin
                    r_phase         <= n_phase;
                    r_param_count   <= n_param_count;
                    r_nul_seen      <= n_nul_seen;
                    r_trailing_open <= n_trailing_open;
                    r_command_seen  <= n_command_seen;
                    r_first_pending <= n_first_pending;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

>>> rtl/core/irc_message_tokenizer.sv
// Top level of the message line tokenizer: front end, queue and back end.
//
//  Channel  Direction  Carries
//  i_in     in         byte_in, line_end
//  o_out    out        byte_out, field_kind, param_index, token_start, end_of_line,
//                      line_valid, trailing_present, param_total, command_present
//
// One byte is accepted every cycle while the queue is not full; each result passes
// through the queue and then through the back end's result register.
// Reset clears the queue, the phase state and the result valid flag.
// A stalled output holds its result; the queue absorbs up to QUEUE_DEPTH bytes
// before the input stalls.
`default_nettype none

module irc_message_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    irc_tok_in_chan.sink     i_in,
    irc_tok_out_chan.source  o_out
);
    import irc_tok_pkg::*;

    t_tok_push push;
    t_tok_head head;
    logic      full;
    logic      pop;

    irc_tok_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push)
    );

    irc_tok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    irc_tok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_start_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.token_start |-> o_out.payload.field_kind != KIND_DROP)
        else $error("token start on a dropped byte");

    a_index_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.field_kind != KIND_MIDDLE
        |-> o_out.payload.param_index == 4'd0)
        else $error("parameter index outside a middle parameter");

    a_invalid_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.end_of_line && !o_out.payload.line_valid
        |-> o_out.payload.param_total == 4'd0 && !o_out.payload.trailing_present
            && !o_out.payload.command_present)
        else $error("summary of a discarded line is not cleared");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("back end took a byte from an empty queue");

endmodule

`default_nettype wire
